[sv/ztf_pkg.sv]
// ztf_pkg: shared types and codes for the zone track filter
// no dependencies; imported by the cells and the top level
`timescale 1ns / 1ps

package ztf_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    localparam int MIN_VERTICES = 3;

    // store size and coordinate width, fixed by the port widths
    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 16;

    // test token passed from cell to cell
    typedef struct packed {
        logic valid;
        logic parity;
        logic on_edge;
    } ztf_tok_t;

endpackage

[sv/ztf_if.sv]
// ztf_in_if / ztf_out_if: valid/ready channels of the zone track filter
// no dependencies
`timescale 1ns / 1ps

interface ztf_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [3:0]  vertex_slot;
    logic [15:0] x_position;
    logic [15:0] y_position;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic        track_active;
    logic [31:0] vehicle_id;
    logic [7:0]  source_tag;
    logic [31:0] frame_seq;
    logic [63:0] frame_time;

    modport source (output valid, cmd, vertex_slot, x_position, y_position, box_width,
                    box_height, track_active, vehicle_id, source_tag, frame_seq,
                    frame_time, input ready);
    modport sink (input valid, cmd, vertex_slot, x_position, y_position, box_width,
                  box_height, track_active, vehicle_id, source_tag, frame_seq,
                  frame_time, output ready);
endinterface

interface ztf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] job_vehicle_id;
    logic [7:0]  job_source_tag;
    logic [31:0] job_frame_seq;
    logic [63:0] job_frame_time;
    logic [15:0] job_box_x;
    logic [15:0] job_box_y;
    logic [15:0] job_box_width;
    logic [15:0] job_box_height;

    modport source (output valid, job_vehicle_id, job_source_tag, job_frame_seq,
                    job_frame_time, job_box_x, job_box_y, job_box_width,
                    job_box_height, input ready);
    modport sink (input valid, job_vehicle_id, job_source_tag, job_frame_seq,
                  job_frame_time, job_box_x, job_box_y, job_box_width,
                  job_box_height, output ready);
endinterface

[sv/zone_track_filter.sv]
// zone_track_filter: polygon zone test of tracked vehicle boxes
// depends on ztf_pkg, ztf_if (ztf_in_if, ztf_out_if) and ztf_cell
//
//   channel   dir   handshake     carries
//   vehicle   in    valid/ready   vertex load or vehicle test request
//   job       out   valid/ready   job for a vehicle inside the zone
//   cfg       in    wr_en only    zone_vertex_count
//
// a load request writes one vertex slot; a test request latches its point, then a
// token runs through MAX_VERTICES cells, one zone edge per cell per cycle
// a job is registered once the token leaves the last cell, and the next request
// is taken only after the test has ended
// vehicle.ready is low while a test runs; a finished hit that finds the job
// register still full keeps the test open until the job is taken
// reset clears the vertex store, the vertex count and all control state
`timescale 1ns / 1ps

module zone_track_filter
    import ztf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ztf_in_if.sink        vehicle,
    ztf_out_if.source     job,
    input  logic          cfg_wr_en,
    input  logic [4:0]    cfg_wr_data
);

    localparam int IDXW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW   = $clog2(MAX_VERTICES + 1);

    // configuration
    logic [4:0]    count_reg;
    logic [NW-1:0] n_eff;
    logic [IDXW-1:0] last_idx;

    // control
    logic busy_reg, busy_next;
    logic out_valid_reg, out_valid_next;
    logic pend_reg, pend_next;
    logic start_reg;
    logic accept, run_start, load_req;
    logic done_hit, load_out;

    // test point, doubled coordinates of the box bottom center
    logic [COORD_BITS-1:0] x_c, y_c, w_c, h_c;
    logic [COORD_BITS+1:0] pt_x_reg, pt_y_reg;

    // held request payload
    logic [31:0] vehicle_id_reg, frame_seq_reg;
    logic [7:0]  source_tag_reg;
    logic [63:0] frame_time_reg;
    logic [15:0] box_x_reg, box_y_reg, box_w_reg, box_h_reg;

    // job register, separate so a new test can run while a job waits
    logic [31:0] out_vehicle_id_reg, out_frame_seq_reg;
    logic [7:0]  out_source_tag_reg;
    logic [63:0] out_frame_time_reg;
    logic [15:0] out_box_x_reg, out_box_y_reg, out_box_w_reg, out_box_h_reg;

    // cell chain
    logic [COORD_BITS-1:0] vx [MAX_VERTICES];
    logic [COORD_BITS-1:0] vy [MAX_VERTICES];
    ztf_tok_t              tok [MAX_VERTICES+1];
    logic [MAX_VERTICES-1:0] tok_valid;
    ztf_tok_t              tail;
    logic                  hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_wr_en)
            count_reg <= cfg_wr_data;
    end

    // counts above the store size act as a full store
    assign n_eff    = (32'(count_reg) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_reg);
    assign last_idx = (n_eff == '0) ? '0 : IDXW'(n_eff - NW'(1));

    assign vehicle.ready = !busy_reg;
    assign accept        = vehicle.valid && vehicle.ready;
    assign load_req      = accept && (vehicle.cmd == CMD_LOAD);
    assign run_start     = accept && (vehicle.cmd == CMD_TEST) && vehicle.track_active;

    // coordinates folded to COORD_BITS
    assign x_c = COORD_BITS'(vehicle.x_position);
    assign y_c = COORD_BITS'(vehicle.y_position);
    assign w_c = COORD_BITS'(vehicle.box_width);
    assign h_c = COORD_BITS'(vehicle.box_height);

    always_ff @(posedge clk)
    begin
        if (run_start)
        begin
            pt_x_reg         <= (COORD_BITS+2)'({x_c, 1'b0}) + (COORD_BITS+2)'(w_c);
            pt_y_reg         <= (COORD_BITS+2)'({y_c, 1'b0}) + (COORD_BITS+2)'({h_c, 1'b0});
            vehicle_id_reg   <= vehicle.vehicle_id;
            source_tag_reg   <= vehicle.source_tag;
            frame_seq_reg    <= vehicle.frame_seq;
            frame_time_reg   <= vehicle.frame_time;
            box_x_reg        <= vehicle.x_position;
            box_y_reg        <= vehicle.y_position;
            box_w_reg        <= vehicle.box_width;
            box_h_reg        <= vehicle.box_height;
        end
    end

    // token enters the first cell the cycle after accept, once the point is held
    assign tok[0] = '{valid: start_reg, parity: 1'b0, on_edge: 1'b0};

    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_cell
        logic [COORD_BITS-1:0] prev_x, prev_y;

        // first cell closes the polygon with the last vertex in use
        if (i == 0)
        begin : g_first
            assign prev_x = vx[last_idx];
            assign prev_y = vy[last_idx];
        end
        else
        begin : g_rest
            assign prev_x = vx[i-1];
            assign prev_y = vy[i-1];
        end

        ztf_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (load_req && (32'(vehicle.vertex_slot) == i)),
            .wr_x    (x_c),
            .wr_y    (y_c),
            .cell_en (i < 32'(n_eff)),
            .prev_x  (prev_x),
            .prev_y  (prev_y),
            .pt_x    (pt_x_reg),
            .pt_y    (pt_y_reg),
            .vert_x  (vx[i]),
            .vert_y  (vy[i]),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );

        assign tok_valid[i] = tok[i+1].valid;
    end

    assign tail = tok[MAX_VERTICES];
    // small zones contain nothing; an edge point is inside
    assign hit  = (32'(n_eff) >= MIN_VERTICES) && (tail.parity || tail.on_edge);

    // a hit moves to the job register as soon as that register is free
    assign done_hit = (tail.valid && hit) || pend_reg;
    assign load_out = done_hit && (!out_valid_reg || job.ready);

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        pend_next      = done_hit && !load_out;
        if (run_start)
            busy_next = 1'b1;
        else if ((tail.valid && !hit) || load_out)
            busy_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
        else if (job.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            start_reg     <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            start_reg     <= run_start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_vehicle_id_reg <= vehicle_id_reg;
            out_source_tag_reg <= source_tag_reg;
            out_frame_seq_reg  <= frame_seq_reg;
            out_frame_time_reg <= frame_time_reg;
            out_box_x_reg      <= box_x_reg;
            out_box_y_reg      <= box_y_reg;
            out_box_w_reg      <= box_w_reg;
            out_box_h_reg      <= box_h_reg;
        end
    end

    assign job.valid          = out_valid_reg;
    assign job.job_vehicle_id = out_vehicle_id_reg;
    assign job.job_source_tag = out_source_tag_reg;
    assign job.job_frame_seq  = out_frame_seq_reg;
    assign job.job_frame_time = out_frame_time_reg;
    assign job.job_box_x      = out_box_x_reg;
    assign job.job_box_y      = out_box_y_reg;
    assign job.job_box_width  = out_box_w_reg;
    assign job.job_box_height = out_box_h_reg;

    // a held hit only waits behind a full job register, with the test open
    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (busy_reg && out_valid_reg))
        else $error("held hit without a waiting job");

    // at most one token in the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid))
        else $error("more than one token in the cell chain");

    // a token only travels during a test
    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid != '0) |-> busy_reg)
        else $error("token without a running test");

    // a started test holds off new requests next cycle
    a_start_block: assert property (@(posedge clk) disable iff (!rst_n)
        run_start |=> !vehicle.ready)
        else $error("request taken during a test");

endmodule

[sv/ztf_cell.sv]
// ztf_cell: one zone vertex and the edge test that ends at it
// depends on ztf_pkg
`timescale 1ns / 1ps

module ztf_cell
    import ztf_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [COORD_BITS-1:0] wr_x,
    input  logic [COORD_BITS-1:0] wr_y,
    input  logic                  cell_en,
    input  logic [COORD_BITS-1:0] prev_x,
    input  logic [COORD_BITS-1:0] prev_y,
    input  logic [COORD_BITS+1:0] pt_x,
    input  logic [COORD_BITS+1:0] pt_y,
    output logic [COORD_BITS-1:0] vert_x,
    output logic [COORD_BITS-1:0] vert_y,
    input  ztf_tok_t              tok_in,
    output ztf_tok_t              tok_out
);

    localparam int D = COORD_BITS + 4;

    logic [COORD_BITS-1:0] vx_reg, vy_reg;
    ztf_tok_t              tok_reg, tok_next;

    logic signed [D-1:0]   ax, ay, bx, by, px, py;
    logic signed [2*D-1:0] p1, p2;
    logic                  in_box, on_line, crosses, right;

    // doubled coordinates
    assign ax = $signed(D'({prev_x, 1'b0}));
    assign ay = $signed(D'({prev_y, 1'b0}));
    assign bx = $signed(D'({vx_reg, 1'b0}));
    assign by = $signed(D'({vy_reg, 1'b0}));
    assign px = $signed(D'(pt_x));
    assign py = $signed(D'(pt_y));

    assign p1 = (py - ay) * (bx - ax);
    assign p2 = (px - ax) * (by - ay);

    assign in_box  = (px >= ax || px >= bx) && (px <= ax || px <= bx) &&
                     (py >= ay || py >= by) && (py <= ay || py <= by);
    assign on_line = (p1 == p2) && in_box;
    assign crosses = (ay > py) != (by > py);
    assign right   = (by > ay) ? (p1 > p2) : (p1 < p2);

    always_comb
    begin
        tok_next = tok_in;
        if (cell_en && tok_in.valid)
        begin
            if (on_line)
                tok_next.on_edge = 1'b1;
            if (crosses && right)
                tok_next.parity = ~tok_in.parity;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg  <= '0;
            vy_reg  <= '0;
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr_en)
            begin
                vx_reg <= wr_x;
                vy_reg <= wr_y;
            end
        end
    end

    assign vert_x  = vx_reg;
    assign vert_y  = vy_reg;
    assign tok_out = tok_reg;

endmodule
